// ----- design/rbfd_pkg.sv -----
// Shared types, widths and codes for the rectangle blit/fill descriptor unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rbfd_pkg;

  localparam int DimW     = 14;          // screen dimension and clipped extent bits
  localparam int StrideW  = 20;
  localparam int AddrW    = 32;
  localparam int BprW     = DimW + 2;    // bytes per row: extent times four
  localparam int CoordW   = 32;          // signed command coordinates
  localparam int AxW      = CoordW + 4;  // headroom for trimmed coordinates
  localparam int ColorW   = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int QPtrW    = 2;
  localparam int QDepth   = 1 << QPtrW;

  localparam int InDataW  = 7 * CoordW;
  localparam int InUserW  = 2;
  localparam int OutDataW = 128;
  localparam int OutUserW = 4;

  localparam logic [1:0] ACT_FILL    = 2'd0;
  localparam logic [1:0] ACT_BLIT    = 2'd1;
  localparam logic [1:0] ACT_PRESENT = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_NO_TARGET = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_FRONT_BASE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FRONT_STRIDE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REAR_BASE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REAR_STRIDE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_W     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_H     = 3'd5;

  typedef logic signed [AxW-1:0] ax_t;
  typedef logic [DimW-1:0]       dim_t;
  typedef logic [AddrW-1:0]      addr_t;
  typedef logic [StrideW-1:0]    stride_t;

  typedef struct packed {
    addr_t   front_base;
    stride_t front_stride;
    addr_t   rear_base;
    stride_t rear_stride;
    dim_t    screen_w;
    dim_t    screen_h;
  } cfg_t;

  // Classified and clipped command, handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        op;
    dim_t              src_x;
    dim_t              src_y;
    dim_t              dst_x;
    dim_t              dst_y;
    dim_t              run_w;
    dim_t              run_h;
    logic              up;
    logic [ColorW-1:0] color;
  } job_t;

endpackage

`default_nettype wire

// ----- design/rbfd_front.sv -----
// Front end: accepts commands, checks size and target buffers, and clips the
// rectangle to the screen in three pipeline stages. Depends on rbfd_pkg.
`default_nettype none

module rbfd_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rbfd_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_action,
  input  wire logic signed [rbfd_pkg::CoordW-1:0] in_pos_x,
  input  wire logic signed [rbfd_pkg::CoordW-1:0] in_pos_y,
  input  wire logic signed [rbfd_pkg::CoordW-1:0] in_dest_x,
  input  wire logic signed [rbfd_pkg::CoordW-1:0] in_dest_y,
  input  wire logic signed [rbfd_pkg::CoordW-1:0] in_rect_w,
  input  wire logic signed [rbfd_pkg::CoordW-1:0] in_rect_h,
  input  wire logic [rbfd_pkg::ColorW-1:0]  in_fill_color,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rbfd_pkg::job_t                    out_job
);
  import rbfd_pkg::*;

  function automatic logic nonpos(input ax_t v);
    return v[AxW-1] || (v == '0);
  endfunction

  function automatic ax_t min2(input ax_t a, input ax_t b);
    return (a < b) ? a : b;
  endfunction

  // Stage 1: status and the trim for a negative source edge.
  logic              v1;
  logic [1:0]        st1, op1;
  logic [ColorW-1:0] color1;
  ax_t               s1x, s1y, d1x, d1y, w1x, w1y;

  // Stage 2: trim for a negative destination edge.
  logic              v2;
  logic [1:0]        st2, op2;
  logic [ColorW-1:0] color2;
  ax_t               s2x, s2y, d2x, d2y, w2x, w2y;

  // Stage 3: clipped command.
  logic v3;
  job_t job3;

  logic en1, en2, en3;

  ax_t        px, py, qx, qy, ax, ay, wx, wy;
  logic       has_rear, front_ok, tgt_ok;
  logic [1:0] st_n;
  ax_t        bx, by;
  ax_t        sw, sh, mx, my;
  logic       empty;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign out_valid = v3;
  assign out_job   = job3;

  // Fill and present are clipped as a blit whose destination equals its source.
  always_comb begin
    px = ax_t'(in_pos_x);
    py = ax_t'(in_pos_y);
    qx = (in_action == ACT_BLIT) ? ax_t'(in_dest_x) : px;
    qy = (in_action == ACT_BLIT) ? ax_t'(in_dest_y) : py;
    ax = px[AxW-1] ? -px : '0;
    ay = py[AxW-1] ? -py : '0;
    wx = ax_t'(in_rect_w);
    wy = ax_t'(in_rect_h);

    has_rear = (cfg.rear_base != '0) && (cfg.rear_stride != '0);
    front_ok = (cfg.front_base != '0) && (cfg.front_stride != '0);
    tgt_ok   = has_rear || front_ok;

    unique case (in_action)
      ACT_FILL, ACT_BLIT: st_n = tgt_ok ? ST_OK : ST_NO_TARGET;
      ACT_PRESENT:        st_n = (has_rear && front_ok) ? ST_OK : ST_NO_TARGET;
      default:            st_n = ST_BAD_SIZE;
    endcase
    if (nonpos(wx) || nonpos(wy)) begin
      st_n = ST_BAD_SIZE;
    end
  end

  always_comb begin
    bx = d1x[AxW-1] ? -d1x : '0;
    by = d1y[AxW-1] ? -d1y : '0;
  end

  always_comb begin
    sw = ax_t'({{(AxW-DimW){1'b0}}, cfg.screen_w});
    sh = ax_t'({{(AxW-DimW){1'b0}}, cfg.screen_h});
    mx = min2(w2x, min2(sw - s2x, sw - d2x));
    my = min2(w2y, min2(sh - s2y, sh - d2y));
    empty = nonpos(mx) || nonpos(my);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      st1    <= st_n;
      op1    <= in_action;
      color1 <= in_fill_color;
      s1x    <= px + ax;
      s1y    <= py + ay;
      d1x    <= qx + ax;
      d1y    <= qy + ay;
      w1x    <= wx - ax;
      w1y    <= wy - ay;
    end
    if (en2) begin
      st2    <= st1;
      op2    <= op1;
      color2 <= color1;
      s2x    <= s1x + bx;
      s2y    <= s1y + by;
      d2x    <= d1x + bx;
      d2y    <= d1y + by;
      w2x    <= w1x - bx;
      w2y    <= w1y - by;
    end
    if (en3) begin
      job3.status <= (st2 == ST_OK && empty) ? ST_EMPTY : st2;
      job3.op     <= op2;
      job3.src_x  <= s2x[DimW-1:0];
      job3.src_y  <= s2y[DimW-1:0];
      job3.dst_x  <= d2x[DimW-1:0];
      job3.dst_y  <= d2y[DimW-1:0];
      job3.run_w  <= mx[DimW-1:0];
      job3.run_h  <= my[DimW-1:0];
      job3.up     <= (op2 == ACT_BLIT) && (d2y > s2y);
      job3.color  <= color2;
    end
  end

endmodule

`default_nettype wire

// ----- design/rbfd_queue.sv -----
// Short job queue between the front end and the back end so either side can
// stall on its own. Depends on rbfd_pkg.
`default_nettype none

module rbfd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rbfd_pkg::job_t in_job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rbfd_pkg::job_t      out_job
);
  import rbfd_pkg::*;

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;
  logic             push, pop;

  assign in_ready  = (count != (QPtrW+1)'(QDepth));
  assign out_valid = (count != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_job;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPtrW+1)'(QDepth))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on pop");
`endif

endmodule

`default_nettype wire

// ----- design/rbfd_back.sv -----
// Back end: turns a clipped job into a row-run descriptor (row select,
// row times stride products, final address sums) and holds the result beat.
// Depends on rbfd_pkg.
`default_nettype none

module rbfd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rbfd_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rbfd_pkg::job_t              in_job,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [1:0]                       out_op_kind,
  output logic [rbfd_pkg::AddrW-1:0]       out_src_addr,
  output logic [rbfd_pkg::AddrW-1:0]       out_dst_addr,
  output logic [rbfd_pkg::BprW-1:0]        out_bytes_per_row,
  output logic [rbfd_pkg::DimW-1:0]        out_row_count,
  output logic                             out_bottom_up,
  output logic [rbfd_pkg::ColorW-1:0]      out_fill_value
);
  import rbfd_pkg::*;

  localparam int ProdW = DimW + StrideW;

  logic    v1, v2, ov;
  logic    en1, en2, en3;
  job_t    job1, job2;
  dim_t    src_row, dst_row;
  addr_t   src_base1, dst_base1, src_base2, dst_base2;
  stride_t src_stride, dst_stride;
  addr_t   src_prod, dst_prod;

  dim_t    first;
  logic    has_rear;
  addr_t   tgt_base, sb_n, db_n;
  stride_t tgt_stride, ss_n, ds_n;

  logic [ProdW-1:0] sp_full, dp_full;
  logic             issued;
  addr_t            src_n, dst_n;

  assign en3       = !ov || out_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = ov;

  // Bottom-up copies start at the last clipped row.
  always_comb begin
    first      = in_job.up ? (in_job.run_h - 1'b1) : '0;
    has_rear   = (cfg.rear_base != '0) && (cfg.rear_stride != '0);
    tgt_base   = has_rear ? cfg.rear_base : cfg.front_base;
    tgt_stride = has_rear ? cfg.rear_stride : cfg.front_stride;
    unique case (in_job.op)
      ACT_FILL: begin
        sb_n = '0;            ss_n = '0;
        db_n = tgt_base;      ds_n = tgt_stride;
      end
      ACT_BLIT: begin
        sb_n = tgt_base;      ss_n = tgt_stride;
        db_n = tgt_base;      ds_n = tgt_stride;
      end
      ACT_PRESENT: begin
        sb_n = cfg.rear_base; ss_n = cfg.rear_stride;
        db_n = cfg.front_base; ds_n = cfg.front_stride;
      end
      default: begin
        sb_n = '0;            ss_n = '0;
        db_n = '0;            ds_n = '0;
      end
    endcase
  end

  always_comb begin
    sp_full = src_row * src_stride;
    dp_full = dst_row * dst_stride;
  end

  always_comb begin
    issued = (job2.status == ST_OK);
    src_n  = src_base2 + src_prod + AddrW'({job2.src_x, 2'b00});
    dst_n  = dst_base2 + dst_prod + AddrW'({job2.dst_x, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      job1       <= in_job;
      src_row    <= in_job.src_y + first;
      dst_row    <= in_job.dst_y + first;
      src_base1  <= sb_n;
      dst_base1  <= db_n;
      src_stride <= ss_n;
      dst_stride <= ds_n;
    end
    if (en2) begin
      job2      <= job1;
      src_base2 <= src_base1;
      dst_base2 <= dst_base1;
      src_prod  <= AddrW'(sp_full);
      dst_prod  <= AddrW'(dp_full);
    end
    if (en3) begin
      out_status        <= job2.status;
      out_op_kind       <= job2.op;
      out_src_addr      <= (issued && job2.op != ACT_FILL) ? src_n : '0;
      out_dst_addr      <= issued ? dst_n : '0;
      out_bytes_per_row <= issued ? BprW'({job2.run_w, 2'b00}) : '0;
      out_row_count     <= issued ? job2.run_h : '0;
      out_bottom_up     <= issued && job2.up;
      out_fill_value    <= (issued && job2.op == ACT_FILL) ? job2.color : '0;
    end
  end

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |->
      out_src_addr == '0 && out_dst_addr == '0 && out_row_count == '0 &&
      out_bytes_per_row == '0 && out_fill_value == '0)
    else $error("rejected descriptor carries payload");
  a_up_blit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bottom_up |-> out_op_kind == ACT_BLIT && out_status == ST_OK)
    else $error("bottom-up set on a non-blit descriptor");
  a_issued_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_OK |-> out_row_count != '0 && out_bytes_per_row != '0)
    else $error("issued descriptor is empty");
`endif

endmodule

`default_nettype wire

// ----- design/rect_blit_fill_descriptor_unit.sv -----
// Top level of the rectangle blit/fill descriptor unit: configuration
// registers, stream packing, front end, job queue and back end.
// Depends on rbfd_pkg, rbfd_front, rbfd_queue and rbfd_back.
//
//   Channel   Dir  Handshake               Payload
//   s_axis    in   s_axis_tvalid/tready    command beat (tdata, tuser)
//   m_axis    out  m_axis_tvalid/tready    descriptor beat (tdata, tuser)
//   cfg       in   cfg_valid/cfg_ready     register index and write data
//
// One command per cycle is accepted while s_axis_tready is high; each gives exactly one descriptor beat.
// A descriptor passes through three front stages (edge trims, then clip), the four-entry queue,
// and three back stages (row select, row-stride multiply, address sum into the output register).
// Reset zeroes the configuration and empties every stage; cfg_ready is always high.
// Output stalls fill the back end, then the queue, then the front end before s_axis_tready drops.
`default_nettype none

module rect_blit_fill_descriptor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_x, pos_y, dest_x, dest_y, rect_w, rect_h, fill_color
  input  wire logic [rbfd_pkg::InDataW-1:0]      s_axis_tdata,
  // action
  input  wire logic [rbfd_pkg::InUserW-1:0]      s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // src_addr, dst_addr, bytes_per_row, row_count, bottom_up, fill_value, zero pad
  output logic [rbfd_pkg::OutDataW-1:0]          m_axis_tdata,
  // status, op_kind
  output logic [rbfd_pkg::OutUserW-1:0]          m_axis_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rbfd_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [rbfd_pkg::CfgDataW-1:0]     cfg_data
);
  import rbfd_pkg::*;

  cfg_t cfg;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  logic [1:0]        d_status, d_op_kind;
  addr_t             d_src_addr, d_dst_addr;
  logic [BprW-1:0]   d_bytes_per_row;
  dim_t              d_row_count;
  logic              d_bottom_up;
  logic [ColorW-1:0] d_fill_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRONT_BASE:   cfg.front_base   <= cfg_data[AddrW-1:0];
        REG_FRONT_STRIDE: cfg.front_stride <= cfg_data[StrideW-1:0];
        REG_REAR_BASE:    cfg.rear_base    <= cfg_data[AddrW-1:0];
        REG_REAR_STRIDE:  cfg.rear_stride  <= cfg_data[StrideW-1:0];
        REG_SCREEN_W:     cfg.screen_w     <= cfg_data[DimW-1:0];
        REG_SCREEN_H:     cfg.screen_h     <= cfg_data[DimW-1:0];
        default: ;
      endcase
    end
  end

  rbfd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_action     (s_axis_tuser[1:0]),
    .in_pos_x      (s_axis_tdata[0*CoordW +: CoordW]),
    .in_pos_y      (s_axis_tdata[1*CoordW +: CoordW]),
    .in_dest_x     (s_axis_tdata[2*CoordW +: CoordW]),
    .in_dest_y     (s_axis_tdata[3*CoordW +: CoordW]),
    .in_rect_w     (s_axis_tdata[4*CoordW +: CoordW]),
    .in_rect_h     (s_axis_tdata[5*CoordW +: CoordW]),
    .in_fill_color (s_axis_tdata[6*CoordW +: ColorW]),
    .out_valid     (fq_valid),
    .out_ready     (fq_ready),
    .out_job       (fq_job)
  );

  rbfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  rbfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (qb_valid),
    .in_ready          (qb_ready),
    .in_job            (qb_job),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_status        (d_status),
    .out_op_kind       (d_op_kind),
    .out_src_addr      (d_src_addr),
    .out_dst_addr      (d_dst_addr),
    .out_bytes_per_row (d_bytes_per_row),
    .out_row_count     (d_row_count),
    .out_bottom_up     (d_bottom_up),
    .out_fill_value    (d_fill_value)
  );

  assign m_axis_tuser = {d_op_kind, d_status};
  assign m_axis_tdata = OutDataW'({d_fill_value, d_bottom_up, d_row_count,
                                   d_bytes_per_row, d_dst_addr, d_src_addr});

endmodule

`default_nettype wire
